>>> rtl/core/wct_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wct_pkg
// Widths, codes and shared types of the weighted choice table.
// ============================================================================
package wct_pkg;

    localparam int ENTRIES     = 16;
    localparam int WEIGHT_BITS = 16;

    localparam int KEY_W  = 16;
    localparam int WIN_W  = 16;
    localparam int DRAW_W = 20;
    localparam int TOT_W  = 20;
    localparam int STAT_W = 2;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ACC_RAW = WEIGHT_BITS + CNT_W;
    localparam int ACC_W   = (ACC_RAW > DRAW_W) ? ACC_RAW : DRAW_W;
    localparam int SUM_W   = ((WEIGHT_BITS > TOT_W) ? WEIGHT_BITS : TOT_W) + 1;
    localparam int ENT_W   = KEY_W + WEIGHT_BITS;

    localparam int IN_TDATA_W  = ((KEY_W + WIN_W + DRAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_W + TOT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1 + STAT_W;

    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        OP_DEFINE = 1'b0,
        OP_SELECT = 1'b1
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [KEY_W-1:0]  key;
        logic [WIN_W-1:0]  weight;
        logic [DRAW_W-1:0] draw;
    } t_item;

    typedef struct packed {
        logic [KEY_W-1:0] chosen_key;
        logic             hit;
        t_status          status;
        logic [TOT_W-1:0] total_weight;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ENT_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic [WIN_W-1:0] w);
        logic [WIN_W+WEIGHT_BITS-1:0] ext;
        ext = {{WEIGHT_BITS{1'b0}}, w};
        return ext[WEIGHT_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/wct_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// wct_ram
// Simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module wct_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wct_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// wct_ctrl
// Walk sequencer: scans stored entries, accumulates weights, appends.
// ============================================================================
module wct_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_vld,
    output logic                                o_item_rdy,
    input  wct_pkg::t_item                      i_item,
    output logic                                o_res_vld,
    input  logic                                i_res_rdy,
    output wct_pkg::t_result                    o_res,
    output wct_pkg::t_ram_req                   o_ram,
    input  logic [wct_pkg::ENT_W-1:0]           i_ram_rdata
);
    import wct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOT_W-1:0]   r_total, n_total;
    logic               r_iss;
    logic               r_rd_vld;
    t_item              r_item;
    logic [IDX_W-1:0]   r_addr;
    logic [ACC_W-1:0]   r_acc;
    logic               r_found;
    logic               r_dup;
    logic [KEY_W-1:0]   r_chosen;

    logic                   item_acc;
    logic [KEY_W-1:0]       rd_key;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [ACC_W-1:0]       acc_sum;
    logic                   hit_now;
    logic                   dup_now;
    logic                   last_iss;
    logic [WEIGHT_BITS-1:0] new_w;
    logic [SUM_W-1:0]       sum_w;
    logic [TOT_W-1:0]       tot_new;
    logic                   full;
    logic                   do_write;

    assign item_acc = i_item_vld && (r_state == S_IDLE);
    assign rd_key   = i_ram_rdata[ENT_W-1:WEIGHT_BITS];
    assign rd_w     = i_ram_rdata[WEIGHT_BITS-1:0];
    assign acc_sum  = r_acc + ACC_W'(rd_w);
    assign hit_now  = r_rd_vld && (r_item.operation == OP_SELECT) && !r_found
                      && (acc_sum > ACC_W'(r_item.draw));
    assign dup_now  = r_rd_vld && (r_item.operation == OP_DEFINE) && (rd_key == r_item.key);
    assign last_iss = (CNT_W'(r_addr) + CNT_W'(1)) == r_count;

    assign new_w    = fit_weight(r_item.weight);
    assign sum_w    = SUM_W'(r_total) + SUM_W'(new_w);
    assign tot_new  = (sum_w > SUM_W'(TOT_MAX)) ? TOT_MAX : sum_w[TOT_W-1:0];
    assign full     = r_count >= CNT_W'(ENTRIES);
    assign do_write = (r_state == S_DONE) && i_res_rdy && (r_item.operation == OP_DEFINE)
                      && !r_dup && !full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (item_acc) begin
                    n_state = (r_count == '0) ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (r_rd_vld && !r_iss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_count = do_write ? r_count + CNT_W'(1) : r_count;
    assign n_total = do_write ? tot_new : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_rd_vld <= (r_state == S_WALK) && r_iss;
            if (item_acc) begin
                r_iss <= (r_count != '0);
            end else if ((r_state == S_WALK) && r_iss && last_iss) begin
                r_iss <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_item   <= i_item;
            r_addr   <= '0;
            r_acc    <= '0;
            r_found  <= 1'b0;
            r_dup    <= 1'b0;
            r_chosen <= '0;
        end else if (r_state == S_WALK) begin
            if (r_iss && !last_iss) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_rd_vld) begin
                r_acc <= acc_sum;
                if (hit_now) begin
                    r_found  <= 1'b1;
                    r_chosen <= rd_key;
                end
                if (dup_now) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    assign o_item_rdy = (r_state == S_IDLE);
    assign o_res_vld  = (r_state == S_DONE);

    always_comb begin
        o_res.chosen_key   = r_found ? r_chosen : '0;
        o_res.hit          = r_found;
        o_res.total_weight = (r_item.operation == OP_DEFINE && !r_dup && !full) ? tot_new
                                                                              : r_total;
        priority if (r_item.operation == OP_SELECT) begin
            o_res.status = ST_OK;
        end else if (r_dup) begin
            o_res.status = ST_DUP;
        end else if (full) begin
            o_res.status = ST_FULL;
        end else begin
            o_res.status = ST_OK;
        end
    end

    assign o_ram.we    = do_write;
    assign o_ram.waddr = r_count[IDX_W-1:0];
    assign o_ram.wdata = {r_item.key, new_w};
    assign o_ram.re    = (r_state == S_WALK) && r_iss;
    assign o_ram.raddr = r_addr;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count))
        |-> (r_count == $past(r_count) + CNT_W'(1)) && $past(do_write))
        else $error("entry count moved without an append");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("total weight decreased");

    a_rd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == S_WALK)
        else $error("read data returned outside the walk");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.hit |-> (o_res.status == ST_OK) && (r_item.operation == OP_SELECT))
        else $error("hit reported on a define");

endmodule

>>> rtl/core/weighted_choice_table.sv
`timescale 1ns / 1ps
// ============================================================================
// weighted_choice_table
// Keyed weight table with append and cumulative-weight selection.
// ============================================================================
// Each item walks the stored entries through the single read port of the
// entry RAM, one entry per cycle; on an empty table the walk is skipped.
// The result then passes from the walker to the output register. A define
// appends in the cycle its result leaves the walker. Items are handled one
// at a time; the next item is taken while a result waits in the output
// register.
module weighted_choice_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key [15:0], weight [31:16], draw [51:32], zero pad above
    input  logic [wct_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // chosen_key [15:0], total_weight [35:16], zero pad above
    output logic [wct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // hit [0], status [2:1]
    output logic [wct_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    import wct_pkg::*;

    t_item        item;
    t_result      res;
    logic         res_vld;
    logic         res_rdy;
    t_ram_req     ram_req;
    logic [ENT_W-1:0] ram_rdata;

    logic         r_out_vld;
    t_result      r_out;

    assign item.operation = t_op'(s_axis_tuser);
    assign item.key       = s_axis_tdata[KEY_W-1:0];
    assign item.weight    = s_axis_tdata[KEY_W+WIN_W-1:KEY_W];
    assign item.draw      = s_axis_tdata[KEY_W+WIN_W+DRAW_W-1:KEY_W+WIN_W];

    wct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (s_axis_tvalid),
        .o_item_rdy  (s_axis_tready),
        .i_item      (item),
        .o_res_vld   (res_vld),
        .i_res_rdy   (res_rdy),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    wct_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.total_weight, r_out.chosen_key});
    assign m_axis_tuser  = {r_out.status, r_out.hit};

endmodule
